// ----- sv/swmm_pkg.sv -----
// Shared types and constants for the 2D sliding-window min/max filter.
// No dependencies.
`default_nettype none
package swmm_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_HALF   = 16;
    localparam int RING       = 2 * MAX_HALF;
    localparam int RING_W     = $clog2(RING);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SIZE_W     = 11;
    localparam int HALF_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int STORE_AW   = RING_W + COL_W;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] filtered_value;
        logic               frame_last;
    } out_item_t;

    // request from the front (row pass) to the back (column pass)
    typedef struct packed {
        logic               wr;      // write row-pass value
        logic [STORE_AW-1:0] waddr;
        logic signed [31:0] wdata;
        logic               emit;    // try to emit next result
        logic [SIZE_W-1:0]  in_col;  // input position after this item
        logic [SIZE_W-1:0]  in_row;
        logic               restart; // new frame: reset output counters
    } req_t;

    typedef struct packed {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [HALF_W-1:0] half;
        logic [HALF_W-1:0] reach;
        logic              max_mode;
    } cfg_t;

    function automatic logic beats(logic signed [31:0] a, logic signed [31:0] b, logic mx);
        beats = mx ? (a > b) : (a < b);
    endfunction
endpackage
`default_nettype wire

// ----- sv/swmm_front.sv -----
// Front: accepts items and runs the row pass; it stalls input until the row pass for the last pixel is done.
// Depends on swmm_pkg.
`default_nettype none
module swmm_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                clr,
    input  wire swmm_pkg::cfg_t      cfg,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire swmm_pkg::in_item_t  in_data,
    output logic                     q_push,
    output swmm_pkg::req_t           q_data,
    input  wire logic                q_full
);
    typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;
    state_t state_reg;
    logic signed [31:0] tail_reg [swmm_pkg::RING];
    logic [swmm_pkg::SIZE_W-1:0] col_reg, row_reg, x_reg, xb_reg, k_reg, hi_reg;
    logic [swmm_pkg::SIZE_W-1:0] ncol_reg, nrow_reg;
    logic signed [31:0] best_reg;
    logic first_reg;
    logic any_reg;

    logic [swmm_pkg::SIZE_W-1:0] c, r, c1, xa, xb, lo, hi, ncol, nrow, w1;
    logic any;
    always_comb
    begin
        c = col_reg; r = row_reg;
        if (row_reg >= cfg.h)
        begin
            c = '0; r = '0;
        end
        w1 = cfg.w - 11'd1;
        c1 = c + 11'd1;
        any = 1'b1; xa = '0; xb = '0;
        if (c1 >= cfg.w)
        begin
            xa = (cfg.w >= 11'(cfg.reach)) ? cfg.w - 11'(cfg.reach) : '0;
            xb = w1;
        end
        else if (c1 >= 11'(cfg.reach))
        begin
            xa = c1 - 11'(cfg.reach); xb = xa;
        end
        else
            any = 1'b0;
        ncol = c1; nrow = r;
        if (c1 >= cfg.w)
        begin
            ncol = '0; nrow = r + 11'd1;
        end
    end

    function automatic logic [swmm_pkg::SIZE_W-1:0] lo_of(logic [swmm_pkg::SIZE_W-1:0] x,
                                                         logic [swmm_pkg::HALF_W-1:0] h);
        lo_of = (x >= 11'(h)) ? x - 11'(h) : '0;
    endfunction
    function automatic logic [swmm_pkg::SIZE_W-1:0] hi_of(logic [swmm_pkg::SIZE_W-1:0] x,
                                                         logic [swmm_pkg::HALF_W-1:0] e,
                                                         logic [swmm_pkg::SIZE_W-1:0] w1);
        logic [swmm_pkg::SIZE_W:0] s;
        s = {1'b0, x} + 12'(e) - 12'd1;
        hi_of = (s > {1'b0, w1}) ? w1 : s[swmm_pkg::SIZE_W-1:0];
    endfunction

    assign lo = lo_of(xa, cfg.half);
    assign hi = hi_of(xa, cfg.reach, w1);

    logic accept;
    assign in_stall = (state_reg != IDLE) || q_full;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        q_push = 1'b0;
        q_data = '0;
        q_data.in_col = ncol_reg;
        q_data.in_row = nrow_reg;
        q_data.waddr = {row_reg[swmm_pkg::RING_W-1:0], x_reg[swmm_pkg::COL_W-1:0]};
        q_data.wdata = best_reg;
        if (accept && in_data.func == swmm_pkg::FUNC_DRAIN)
        begin
            q_push = 1'b1;
            q_data.emit = 1'b1;
            q_data.in_col = col_reg;
            q_data.in_row = row_reg;
        end
        else if (state_reg == FINISH && !q_full)
        begin
            // row value complete for x_reg
            q_push = 1'b1;
            q_data.wr = 1'b1;
            q_data.emit = (x_reg == xb_reg);
            q_data.restart = first_reg && (x_reg == xb_reg);
        end
        else if (state_reg == SCAN && !any_reg && !q_full)
        begin
            q_push = 1'b1;
            q_data.emit = 1'b1;
            q_data.restart = first_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE; col_reg <= '0; row_reg <= '0; any_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else if (clr)
        begin
            state_reg <= IDLE; col_reg <= '0; row_reg <= '0;
        end
        else
        begin
            case (state_reg)
            IDLE:
                if (accept && in_data.func == swmm_pkg::FUNC_PIXEL)
                begin
                    tail_reg[c[swmm_pkg::RING_W-1:0]] <= in_data.pixel_value;
                    first_reg <= (row_reg >= cfg.h);
                    row_reg <= r; col_reg <= c;
                    ncol_reg <= ncol; nrow_reg <= nrow;
                    any_reg <= any;
                    x_reg <= xa; xb_reg <= xb;
                    k_reg <= lo; hi_reg <= hi;
                    best_reg <= (c[swmm_pkg::RING_W-1:0] == lo[swmm_pkg::RING_W-1:0])
                                ? in_data.pixel_value : tail_reg[lo[swmm_pkg::RING_W-1:0]];
                    state_reg <= SCAN;
                end
            SCAN:
                if (!any_reg)
                begin
                    if (!q_full)
                    begin
                        state_reg <= IDLE;
                        col_reg <= ncol_reg; row_reg <= nrow_reg;
                    end
                end
                else if (k_reg >= hi_reg)
                    state_reg <= FINISH;
                else
                begin
                    k_reg <= k_reg + 11'd1;
                    if (swmm_pkg::beats(tail_reg[k_reg[swmm_pkg::RING_W-1:0] + 1'b1],
                                        best_reg, cfg.max_mode))
                        best_reg <= tail_reg[k_reg[swmm_pkg::RING_W-1:0] + 1'b1];
                end
            FINISH:
                if (!q_full)
                begin
                    if (x_reg == xb_reg)
                    begin
                        state_reg <= IDLE;
                        col_reg <= ncol_reg; row_reg <= nrow_reg;
                    end
                    else
                    begin
                        x_reg <= x_reg + 11'd1;
                        k_reg <= lo_of(x_reg + 11'd1, cfg.half);
                        hi_reg <= hi_of(x_reg + 11'd1, cfg.reach, cfg.w - 11'd1);
                        best_reg <= tail_reg[lo_of(x_reg + 11'd1, cfg.half)
                                             [swmm_pkg::RING_W-1:0]];
                        state_reg <= SCAN;
                    end
                end
            default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/swmm_queue.sv -----
// Short request queue between the row pass and the column pass.
// Depends on swmm_pkg.
`default_nettype none
module swmm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           clr,
    input  wire logic           push,
    input  wire swmm_pkg::req_t wdata,
    output logic                full,
    input  wire logic           pop,
    output swmm_pkg::req_t      rdata,
    output logic                nonempty
);
    swmm_pkg::req_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    assign full = cnt_reg[2];
    assign nonempty = cnt_reg != 3'd0;
    assign rdata = mem_reg[rp_reg];
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= wdata;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else if (clr)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push && !full) wp_reg <= wp_reg + 2'd1;
            if (pop && nonempty) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push && !full) - 3'(pop && nonempty);
        end
    end
endmodule
`default_nettype wire

// ----- sv/swmm_back.sv -----
// Back: row-extreme store and column pass, one store read per cycle.
// Depends on swmm_pkg.
`default_nettype none
module swmm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clr,
    input  wire swmm_pkg::cfg_t    cfg,
    input  wire logic              q_nonempty,
    input  wire swmm_pkg::req_t    q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output swmm_pkg::out_item_t    out_data
);
    typedef enum logic [1:0] {IDLE, RD, SCAN} state_t;
    state_t state_reg;
    logic signed [31:0] store_mem [2**swmm_pkg::STORE_AW];
    logic signed [31:0] rd_reg, best_reg;
    logic [swmm_pkg::SIZE_W-1:0] ocol_reg, orow_reg, icol_reg, irow_reg, k_reg, hy_reg;
    logic first_reg, valid_reg;
    swmm_pkg::out_item_t out_reg;
    logic [swmm_pkg::STORE_AW-1:0] raddr;

    logic [swmm_pkg::SIZE_W-1:0] w1, h1, ox, oy, hx, hy, lo;
    logic [swmm_pkg::SIZE_W:0] sx, sy;
    logic [21:0] got, need;
    logic ready;
    always_comb
    begin
        w1 = cfg.w - 11'd1; h1 = cfg.h - 11'd1;
        ox = ocol_reg; oy = orow_reg;
        sx = {1'b0, ox} + 12'(cfg.reach) - 12'd1;
        sy = {1'b0, oy} + 12'(cfg.reach) - 12'd1;
        hx = (sx > {1'b0, w1}) ? w1 : sx[swmm_pkg::SIZE_W-1:0];
        hy = (sy > {1'b0, h1}) ? h1 : sy[swmm_pkg::SIZE_W-1:0];
        lo = (oy >= 11'(cfg.half)) ? oy - 11'(cfg.half) : '0;
        got = 22'(irow_reg) * 22'(cfg.w) + 22'(icol_reg);
        need = 22'(hy) * 22'(cfg.w) + 22'(hx);
        ready = (oy < cfg.h) && (ox < cfg.w) && (need < got);
    end

    assign q_pop = (state_reg == IDLE) && q_nonempty && !(valid_reg && out_stall);
    assign out_valid = valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.wr)
            store_mem[q_data.waddr] <= q_data.wdata;
        rd_reg <= store_mem[raddr];
    end

    always_comb
    begin
        raddr = {k_reg[swmm_pkg::RING_W-1:0], ocol_reg[swmm_pkg::COL_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE; valid_reg <= 1'b0;
            ocol_reg <= '0; orow_reg <= '0; icol_reg <= '0; irow_reg <= '0;
        end
        else if (clr)
        begin
            state_reg <= IDLE; valid_reg <= 1'b0;
            ocol_reg <= '0; orow_reg <= '0; icol_reg <= '0; irow_reg <= '0;
        end
        else
        begin
            if (valid_reg && !out_stall) valid_reg <= 1'b0;
            case (state_reg)
            IDLE:
                if (q_pop)
                begin
                    if (q_data.restart)
                    begin
                        ocol_reg <= '0; orow_reg <= '0;
                    end
                    if (q_data.emit)
                    begin
                        icol_reg <= q_data.in_col; irow_reg <= q_data.in_row;
                        state_reg <= RD;
                    end
                end
            RD:
                // lo row loaded into k_reg here; its address is presented in SCAN
                if (ready)
                begin
                    k_reg <= lo; hy_reg <= hy; first_reg <= 1'b1;
                    state_reg <= SCAN;
                end
                else
                    state_reg <= IDLE;
            SCAN:
            begin
                // rd_reg holds row k_reg - 1 once the first read is out
                if (first_reg)
                begin
                    first_reg <= 1'b0;
                    k_reg <= k_reg + 11'd1;
                end
                else
                begin
                    if (k_reg == lo + 11'd1 || swmm_pkg::beats(rd_reg, best_reg, cfg.max_mode))
                        best_reg <= rd_reg;
                    if (k_reg > hy_reg)
                    begin
                        out_reg.filtered_value <=
                            (k_reg == lo + 11'd1 || swmm_pkg::beats(rd_reg, best_reg,
                             cfg.max_mode)) ? rd_reg : best_reg;
                        out_reg.frame_last <= (ocol_reg == w1) && (orow_reg == h1);
                        valid_reg <= 1'b1;
                        if (ocol_reg + 11'd1 >= cfg.w)
                        begin
                            ocol_reg <= '0; orow_reg <= orow_reg + 11'd1;
                        end
                        else
                            ocol_reg <= ocol_reg + 11'd1;
                        state_reg <= IDLE;
                    end
                    else
                        k_reg <= k_reg + 11'd1;
                end
            end
            default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/sliding_window_min_max_2d_core.sv -----
// Top level of the 2D sliding-window min/max filter.
// Depends on swmm_pkg, swmm_front, swmm_queue, swmm_back.
//
// Usage: pixels enter in raster order on in_valid/in_stall (func 0 carries a
// sample, func 1 is a drain that only flushes pending results). Results leave
// on out_valid/out_stall in raster order, at most one per request, held in an
// output register while the receiver stalls (back pressure reaches the input
// through a four-entry request queue).
// Flow: a pixel occupies the row pass from IDLE through SCAN over the window
// span and FINISH for each column it finishes, or SCAN alone when it
// finishes none; the span is up to 2h. A result goes through RD and then SCAN
// over the window rows (up to 2h) in the column pass, one store read per cycle.
// Reset: counters clear, registers go to W=1024, H=1024, h=1, min mode. The
// store is not cleared; it is only read where written. A configuration write
// restarts the frame and drops results not yet delivered.
`default_nettype none
module sliding_window_min_max_2d_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire swmm_pkg::in_item_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output swmm_pkg::out_item_t                     out_data,
    input  wire logic                               cfg_we,
    input  wire logic [swmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [swmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    logic [10:0] w_reg, h_reg;
    logic [4:0] half_reg;
    logic mode_reg;
    swmm_pkg::cfg_t cfg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= 11'd1024; h_reg <= 11'd1024; half_reg <= 5'd1; mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
            swmm_pkg::REG_WIDTH:  w_reg <= cfg_data;
            swmm_pkg::REG_HEIGHT: h_reg <= cfg_data;
            swmm_pkg::REG_HALF:   half_reg <= cfg_data[4:0];
            swmm_pkg::REG_MODE:   mode_reg <= cfg_data[0];
            default: ;
            endcase
        end
    end
    always_comb
    begin
        cfg.w = (w_reg == '0) ? 11'd1 : (w_reg > 11'(swmm_pkg::MAX_WIDTH))
                ? 11'(swmm_pkg::MAX_WIDTH) : w_reg;
        cfg.h = (h_reg == '0) ? 11'd1 : (h_reg > 11'(swmm_pkg::MAX_HEIGHT))
                ? 11'(swmm_pkg::MAX_HEIGHT) : h_reg;
        cfg.half = (half_reg > 5'(swmm_pkg::MAX_HALF)) ? 5'(swmm_pkg::MAX_HALF) : half_reg;
        cfg.reach = (cfg.half == '0) ? 5'd1 : cfg.half;
        cfg.max_mode = mode_reg;
    end

    logic q_push, q_full, q_pop, q_ne;
    swmm_pkg::req_t q_in, q_out;

    swmm_front u_front (.clk, .rst_n, .clr(cfg_we), .cfg, .in_valid, .in_stall, .in_data,
                        .q_push, .q_data(q_in), .q_full);
    swmm_queue u_queue (.clk, .rst_n, .clr(cfg_we), .push(q_push), .wdata(q_in),
                        .full(q_full), .pop(q_pop), .rdata(q_out), .nonempty(q_ne));
    swmm_back u_back (.clk, .rst_n, .clr(cfg_we), .cfg, .q_nonempty(q_ne), .q_data(q_out),
                      .q_pop, .out_valid, .out_stall, .out_data);

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !(q_push && !q_pop)) else $error("push into full queue dropped");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && !cfg_we) |=> out_valid) else $error("result lost");
    a_pop_ne: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_ne) else $error("pop of empty queue");
endmodule
`default_nettype wire
